[sv/csfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSF builder package
// Shared constants, codes and the job record passed from the front end to the
// back end of the COO to CSF list builder.
// ----------------------------------------------------------------------------
package csfb_pkg;

    localparam int MAX_MODES  = 4;
    localparam int INDEX_BITS = 32;
    localparam int VALUE_BITS = 64;

    localparam int COORD_FIELDS = 4;
    localparam int CFG_W        = 3;
    localparam int COORD_IN_W   = 32;
    localparam int PAYLOAD_W    = 64;
    localparam int LEVEL_W      = 2;
    localparam int KIND_W       = 2;

    localparam int NUM_MODES  = (MAX_MODES < COORD_FIELDS) ? MAX_MODES : COORD_FIELDS;
    localparam int NUM_LEVELS = NUM_MODES - 1;
    localparam int COORD_W    = (INDEX_BITS < COORD_IN_W) ? INDEX_BITS : COORD_IN_W;
    localparam int STEP_W     = 3;
    localparam int COUNT_W    = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE   = 2'd0,
        KIND_INDEX   = 2'd1,
        KIND_POINTER = 2'd2
    } t_kind;

    typedef struct packed {
        logic                                  finish;
        logic [LEVEL_W-1:0]                    first_diff;
        logic [COUNT_W-1:0]                    num_words;
        logic [NUM_MODES-1:0][COORD_W-1:0]     coords;
        logic [NUM_LEVELS-1:0][INDEX_BITS-1:0] counts;
        logic [VALUE_BITS-1:0]                 value;
    } t_job;

endpackage

[sv/csfb_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSF builder entry channel
// Valid/ready channel carrying one tensor entry or a finish command.
// ----------------------------------------------------------------------------
interface csfb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    logic [31:0] coord_3;
    logic [63:0] entry_value;

    modport source (output valid, cmd, coord_0, coord_1, coord_2, coord_3, entry_value,
                    input ready);
    modport sink (input valid, cmd, coord_0, coord_1, coord_2, coord_3, entry_value,
                  output ready);
endinterface

[sv/csfb_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSF builder list channel
// Valid/ready channel carrying one CSF list word.
// ----------------------------------------------------------------------------
interface csfb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  level;
    logic [63:0] payload;
    logic        last;

    modport source (output valid, kind, level, payload, last, input ready);
    modport sink (input valid, kind, level, payload, last, output ready);
endinterface

[sv/csfb_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSF builder configuration channel
// Valid/ready write channel for the active mode count register.
// ----------------------------------------------------------------------------
interface csfb_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[sv/csfb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSF builder front end
// Accepts entries, finds the first differing mode, snapshots the fiber
// counts into a job and updates the running builder state.
// ----------------------------------------------------------------------------
module csfb_front
    import csfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    csfb_in_if.sink     i_entry,
    csfb_cfg_if.sink    i_cfg,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [CFG_W-1:0]                    r_modes;
    logic                                r_have;
    logic [NUM_MODES-1:0][COORD_W-1:0]   r_prev;
    logic [NUM_LEVELS-1:0][INDEX_BITS-1:0] r_cnt;

    logic                                accept;
    logic [CFG_W-1:0]                    modes;
    logic [NUM_MODES-1:0][COORD_W-1:0]   coords;
    logic [LEVEL_W-1:0]                  diff;
    logic [LEVEL_W-1:0]                  inc_lo;
    logic                                found;
    logic [NUM_LEVELS-1:0][INDEX_BITS-1:0] n_cnt;
    logic [COUNT_W-1:0]                  num_words;

    assign i_cfg.ready   = 1'b1;
    assign i_entry.ready = !i_full;
    assign accept        = i_entry.valid && !i_full;

    always_comb begin
        if (r_modes < CFG_W'(2)) begin
            modes = CFG_W'(2);
        end else if (r_modes > CFG_W'(NUM_MODES)) begin
            modes = CFG_W'(NUM_MODES);
        end else begin
            modes = r_modes;
        end
    end

    assign coords[0] = i_entry.coord_0[COORD_W-1:0];
    assign coords[1] = i_entry.coord_1[COORD_W-1:0];
    assign coords[2] = i_entry.coord_2[COORD_W-1:0];
    assign coords[3] = i_entry.coord_3[COORD_W-1:0];

    always_comb begin
        found = 1'b0;
        diff  = LEVEL_W'(modes - CFG_W'(1));
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (!found && (CFG_W'(i) < modes - CFG_W'(1)) && (coords[i] != r_prev[i])) begin
                diff  = LEVEL_W'(i);
                found = 1'b1;
            end
        end
        if (!r_have) begin
            diff = '0;
        end
    end

    assign inc_lo = (diff == '0) ? '0 : diff - LEVEL_W'(1);

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            n_cnt[l] = r_cnt[l];
            if ((LEVEL_W'(l) >= inc_lo) && (CFG_W'(l) < modes - CFG_W'(1))
                    && (r_cnt[l] != '1)) begin
                n_cnt[l] = r_cnt[l] + INDEX_BITS'(1);
            end
        end
    end

    always_comb begin
        if (i_entry.cmd) begin
            num_words = COUNT_W'(modes) - COUNT_W'(1);
        end else begin
            num_words = (COUNT_W'(modes) - COUNT_W'(diff)) << 1;
        end
    end

    assign o_push           = accept;
    assign o_job.finish     = i_entry.cmd;
    assign o_job.first_diff = diff;
    assign o_job.num_words  = num_words;
    assign o_job.coords     = coords;
    assign o_job.counts     = r_cnt;
    assign o_job.value      = i_entry.entry_value[VALUE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modes <= CFG_W'(4);
            r_have  <= 1'b0;
            r_prev  <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_modes <= i_cfg.data;
            end
            if (accept) begin
                if (i_entry.cmd) begin
                    r_have <= 1'b0;
                    r_prev <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_have <= 1'b1;
                    r_prev <= coords;
                    r_cnt  <= n_cnt;
                end
            end
        end
    end

endmodule

[sv/csfb_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSF builder job queue
// Two-entry queue of jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module csfb_queue
    import csfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[sv/csfb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSF builder back end
// Walks the head job to an output register, a word per cycle unless stalled.
// ----------------------------------------------------------------------------
module csfb_back
    import csfb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_job      i_job,
    output logic      o_pop,
    csfb_out_if.source o_list
);

    logic [STEP_W-1:0]    r_step;
    logic                 r_valid;
    t_kind                r_kind;
    logic [LEVEL_W-1:0]   r_level;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                 r_last;

    logic                 load;
    logic                 emit;
    logic                 is_last;
    logic [LEVEL_W-1:0]   lvl;
    t_kind                n_kind;
    logic [LEVEL_W-1:0]   n_level;
    logic [PAYLOAD_W-1:0] n_payload;

    assign load    = !r_valid || o_list.ready;
    assign emit    = load && i_valid;
    assign is_last = (COUNT_W'(r_step) == i_job.num_words - COUNT_W'(1));
    assign o_pop   = emit && is_last;
    assign lvl     = i_job.first_diff + LEVEL_W'(r_step >> 1);

    always_comb begin
        if (i_job.finish) begin
            n_kind    = KIND_POINTER;
            n_level   = LEVEL_W'(r_step);
            n_payload = PAYLOAD_W'(i_job.counts[LEVEL_W'(r_step)]);
        end else if (!r_step[0]) begin
            n_kind    = KIND_INDEX;
            n_level   = lvl;
            n_payload = PAYLOAD_W'(i_job.coords[lvl]);
        end else if (is_last) begin
            n_kind    = KIND_VALUE;
            n_level   = lvl;
            n_payload = PAYLOAD_W'(i_job.value);
        end else begin
            n_kind    = KIND_POINTER;
            n_level   = lvl;
            n_payload = PAYLOAD_W'(i_job.counts[lvl]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid   <= 1'b1;
                r_kind    <= n_kind;
                r_level   <= n_level;
                r_payload <= n_payload;
                r_last    <= is_last;
                r_step    <= is_last ? '0 : r_step + STEP_W'(1);
            end else if (load) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_list.valid   = r_valid;
    assign o_list.kind    = r_kind;
    assign o_list.level   = r_level;
    assign o_list.payload = r_payload;
    assign o_list.last    = r_last;

endmodule

[sv/coo_to_csf_builder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COO to CSF builder
// Turns a lexicographically ordered stream of nonzero entries into a stream
// of compressed sparse fiber list words.
//
//   Port      Direction  Carries
//   i_entry   in         command, four coordinates, value word
//   i_cfg     in         active mode count (3 bits)
//   o_list    out        kind, level, payload, last flag
//
// An entry that first differs at mode d yields 2*(M-d) list words and a
// finish yields M-1, one word per cycle from the back end's output register.
// The front end takes a new transaction every cycle while the two-entry job
// queue has room, so the sustained rate is set by the list word count.
// Reset is synchronous and clears the counts, the previous entry and the
// queue; a stall on o_list backs up through the queue to i_entry.ready.
// ----------------------------------------------------------------------------
module coo_to_csf_builder_unit
    import csfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    csfb_in_if.sink    i_entry,
    csfb_cfg_if.sink   i_cfg,
    csfb_out_if.source o_list
);

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_job push_job;
    t_job head_job;

    csfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (i_entry),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    csfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    csfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_list  (o_list)
    );

endmodule
